// ===== rtl/core/rssi_source_table_ranker_core_macros.svh =====
// Assertion macros for the source table ranker checker.
// Depends on a clk and rst signal in the scope of use.
`ifndef RSSI_SOURCE_TABLE_RANKER_CORE_MACROS_SVH
`define RSSI_SOURCE_TABLE_RANKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSTR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rstr assertion failed");

// Next-cycle implication, disabled during reset.
`define RSTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rstr assertion failed");

`endif

// ===== rtl/core/rstr_pkg.sv =====
// Shared constants, types and control structs of the source table ranker.
// No dependencies.
`default_nettype none
package rstr_pkg;

  localparam int SLOTS      = 16;
  localparam int MAX_TUPLES = 8;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int TUP_W      = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;
  localparam int LEN_W      = $clog2(MAX_TUPLES + 1);
  localparam int HASH_W     = 24;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 24;
  localparam int MEAN_W     = 8;
  localparam int SHORT_W    = 8;
  localparam int WP_W       = 16;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [SHORT_W-1:0] SHORT_MAX = 8'd255;

  typedef enum logic [1:0] {
    CMD_OPEN    = 2'd0,
    CMD_NOTE    = 2'd1,
    CMD_SUM     = 2'd2,
    CMD_INCLUDE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOTE_SCAN,
    ST_NOTE_DECIDE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SUM_SCAN,
    ST_SUM_PICK,
    ST_SUM_EMIT,
    ST_INC_MSG,
    ST_INC_SLOT,
    ST_INC_REP,
    ST_INC_FAIL
  } state_t;

  typedef enum logic [1:0] {
    OSEL_SUM,
    OSEL_SUM_NONE,
    OSEL_INC,
    OSEL_INC_FAIL
  } osel_t;

  typedef struct packed {
    logic  load;
    logic  do_open;
    logic  note_count;
    logic  scan_clr;
    logic  step_note;
    logic  step_rank;
    logic  step_idx;
    logic  step_msg;
    logic  note_write;
    logic  note_bump;
    logic  div_go;
    logic  div_store;
    logic  sum_close;
    logic  sum_take;
    logic  inc_start;
    logic  inc_take;
    logic  emit_next;
    logic  out_load;
    osel_t osel;
  } ctl_t;

  typedef struct packed {
    logic in_hash_zero;
    logic wopen;
    logic idx_last;
    logic match_hit;
    logic count_full;
    logic note_take;
    logic best_v;
    logic tup_full_next;
    logic msg_hit;
    logic msg_more;
    logic msg_empty;
    logic emit_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rstr_channels.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on rstr_pkg for field widths.
`default_nettype none
interface rstr_item_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic [rstr_pkg::HASH_W-1:0]      hash;
  logic signed [7:0]                rssi;
  modport source (output valid, command, hash, rssi, input ready);
  modport sink   (input valid, command, hash, rssi, output ready);
endinterface

interface rstr_res_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic                             valid_res;
  logic [2:0]                       position;
  logic [rstr_pkg::HASH_W-1:0]      source_hash;
  logic signed [rstr_pkg::MEAN_W-1:0] avg_rssi;
  logic [rstr_pkg::SHORT_W-1:0]     packet_count;
  logic [rstr_pkg::WP_W-1:0]        total_packets;
  logic                             last;
  modport source (output valid, kind, valid_res, position, source_hash, avg_rssi,
                  packet_count, total_packets, last, input ready);
  modport sink   (input valid, kind, valid_res, position, source_hash, avg_rssi,
                  packet_count, total_packets, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rssi_source_table_ranker_core.sv =====
// Top level of the RSSI source table ranker: controller plus datapath.
// Depends on rstr_pkg, rstr_channels, rstr_ctrl, rstr_dp (and rstr_div).
//
//   channel   dir  handshake            payload
//   item      in   item.valid/ready     command, hash, rssi
//   res       out  res.valid/ready      kind, valid_res, position, source_hash,
//                                       avg_rssi, packet_count, total_packets, last
//   cfg       in   cfg_we               cfg_wdata -> min_packets
//
// One item at a time; item.ready is high only while the sequencer is idle.
// Open, and a note in a closed window, finish in the accept cycle. A note in an
// open window scans the slots to a match or the last one, then decides whether
// to place it; a match adds to the slot and, unless its count is full, runs the
// shared 24-step mean divider. Summarize ranks a tuple per slot scan, then emits
// the results. Include scans the message, then the slots. A stalled res holds the
// output register; the next item is still taken while a result waits.
// Synchronous reset clears the table valid bits, message length, window and state.
`default_nettype none
module rssi_source_table_ranker_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  rstr_item_if.sink       item,
  rstr_res_if.source      res
);
  rstr_pkg::ctl_t ctl;
  rstr_pkg::sts_t sts;
  logic           in_ready;

  // hand control only through the command and status structs
  rstr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_command (item.command),
    .sts        (sts),
    .in_ready   (in_ready),
    .ctl        (ctl)
  );

  rstr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_hash   (item.hash),
    .in_rssi   (item.rssi),
    .ctl       (ctl),
    .sts       (sts),
    .res       (res)
  );

  assign item.ready = in_ready;
endmodule
`default_nettype wire

// ===== rtl/core/rstr_div.sv =====
// Restoring divider for slot means: signed sum over unsigned count, truncating.
// Depends on rstr_pkg.
`default_nettype none
module rstr_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [rstr_pkg::SUM_W-1:0]  dividend,
  input  wire logic [rstr_pkg::COUNT_W-1:0]       divisor,
  output logic                                    done,
  output logic signed [rstr_pkg::MEAN_W-1:0]      quotient
);
  logic [rstr_pkg::SUM_W-1:0]     acc;
  logic [rstr_pkg::COUNT_W-1:0]   rem;
  logic [rstr_pkg::COUNT_W-1:0]   dvs;
  logic                           neg;
  logic                           busy;
  logic [rstr_pkg::DIV_CNT_W-1:0] cnt;
  logic [rstr_pkg::COUNT_W:0]     rem_sh;
  logic                           qbit;
  logic [rstr_pkg::SUM_W-1:0]     q_signed;

  always_comb begin
    rem_sh   = {rem, acc[rstr_pkg::SUM_W-1]};
    qbit     = (rem_sh >= {1'b0, dvs});
    q_signed = neg ? (~acc + 1'b1) : acc;
    quotient = q_signed[rstr_pkg::MEAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= rstr_pkg::DIV_CNT_W'(rstr_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rstr_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[rstr_pkg::SUM_W-1];
      acc <= dividend[rstr_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= qbit ? rstr_pkg::COUNT_W'(rem_sh - {1'b0, dvs})
                  : rem_sh[rstr_pkg::COUNT_W-1:0];
      acc <= {acc[rstr_pkg::SUM_W-2:0], qbit};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rstr_ctrl.sv =====
// Command sequencer of the source table ranker.
// Depends on rstr_pkg; drives the datapath through ctl_t, watches sts_t.
`default_nettype none
module rstr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_command,
  input  wire rstr_pkg::sts_t sts,
  output logic                in_ready,
  output rstr_pkg::ctl_t      ctl
);
  rstr_pkg::state_t state, state_next;
  rstr_pkg::cmd_t   cmd;

  assign cmd = rstr_pkg::cmd_t'(in_command);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rstr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rstr_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            rstr_pkg::CMD_OPEN:    state_next = rstr_pkg::ST_IDLE;
            rstr_pkg::CMD_NOTE:    state_next = sts.wopen ? rstr_pkg::ST_NOTE_SCAN
                                                          : rstr_pkg::ST_IDLE;
            rstr_pkg::CMD_SUM:     state_next = rstr_pkg::ST_SUM_SCAN;
            rstr_pkg::CMD_INCLUDE: state_next = sts.in_hash_zero ? rstr_pkg::ST_INC_FAIL
                                                                 : rstr_pkg::ST_INC_MSG;
            default:               state_next = rstr_pkg::ST_IDLE;
          endcase
        end
      end
      rstr_pkg::ST_NOTE_SCAN: begin
        if (sts.match_hit) begin
          state_next = sts.count_full ? rstr_pkg::ST_IDLE : rstr_pkg::ST_DIV_START;
        end else if (sts.idx_last) begin
          state_next = rstr_pkg::ST_NOTE_DECIDE;
        end
      end
      rstr_pkg::ST_NOTE_DECIDE: state_next = rstr_pkg::ST_IDLE;
      rstr_pkg::ST_DIV_START:   state_next = rstr_pkg::ST_DIV_WAIT;
      rstr_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) state_next = rstr_pkg::ST_IDLE;
      end
      rstr_pkg::ST_SUM_SCAN: begin
        if (sts.idx_last) state_next = rstr_pkg::ST_SUM_PICK;
      end
      rstr_pkg::ST_SUM_PICK: begin
        if (sts.best_v && !sts.tup_full_next) state_next = rstr_pkg::ST_SUM_SCAN;
        else                                  state_next = rstr_pkg::ST_SUM_EMIT;
      end
      rstr_pkg::ST_SUM_EMIT: begin
        if (sts.out_free && (sts.msg_empty || sts.emit_last)) state_next = rstr_pkg::ST_IDLE;
      end
      rstr_pkg::ST_INC_MSG: begin
        if (sts.msg_hit)        state_next = rstr_pkg::ST_INC_REP;
        else if (!sts.msg_more) state_next = rstr_pkg::ST_INC_SLOT;
      end
      rstr_pkg::ST_INC_SLOT: begin
        if (sts.match_hit)     state_next = rstr_pkg::ST_INC_REP;
        else if (sts.idx_last) state_next = rstr_pkg::ST_INC_FAIL;
      end
      rstr_pkg::ST_INC_REP,
      rstr_pkg::ST_INC_FAIL: begin
        if (sts.out_free) state_next = rstr_pkg::ST_IDLE;
      end
      default: state_next = rstr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.osel = rstr_pkg::OSEL_SUM;
    in_ready = (state == rstr_pkg::ST_IDLE);
    unique case (state)
      rstr_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          unique case (cmd)
            rstr_pkg::CMD_OPEN: ctl.do_open = 1'b1;
            rstr_pkg::CMD_NOTE: begin
              ctl.note_count = sts.wopen;
              ctl.scan_clr   = sts.wopen;
            end
            rstr_pkg::CMD_SUM: begin
              ctl.sum_close = 1'b1;
              ctl.scan_clr  = 1'b1;
            end
            rstr_pkg::CMD_INCLUDE: begin
              ctl.inc_start = 1'b1;
              ctl.scan_clr  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      rstr_pkg::ST_NOTE_SCAN: begin
        if (sts.match_hit) ctl.note_bump = !sts.count_full;
        else               ctl.step_note = 1'b1;
      end
      rstr_pkg::ST_NOTE_DECIDE: ctl.note_write = sts.note_take;
      rstr_pkg::ST_DIV_START:   ctl.div_go = 1'b1;
      rstr_pkg::ST_DIV_WAIT:    ctl.div_store = sts.div_done;
      rstr_pkg::ST_SUM_SCAN:    ctl.step_rank = 1'b1;
      rstr_pkg::ST_SUM_PICK: begin
        ctl.sum_take = sts.best_v;
        ctl.scan_clr = sts.best_v && !sts.tup_full_next;
      end
      rstr_pkg::ST_SUM_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load  = 1'b1;
          ctl.osel      = sts.msg_empty ? rstr_pkg::OSEL_SUM_NONE : rstr_pkg::OSEL_SUM;
          ctl.emit_next = !sts.msg_empty && !sts.emit_last;
        end
      end
      rstr_pkg::ST_INC_MSG: begin
        ctl.step_msg = !sts.msg_hit && sts.msg_more;
      end
      rstr_pkg::ST_INC_SLOT: begin
        if (sts.match_hit) ctl.inc_take = 1'b1;
        else               ctl.step_idx = !sts.idx_last;
      end
      rstr_pkg::ST_INC_REP: begin
        ctl.out_load = sts.out_free;
        ctl.osel     = rstr_pkg::OSEL_INC;
      end
      rstr_pkg::ST_INC_FAIL: begin
        ctl.out_load = sts.out_free;
        ctl.osel     = rstr_pkg::OSEL_INC_FAIL;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/rstr_dp.sv =====
// Datapath: slot table, cached means, message, scan trackers, output register.
// Depends on rstr_pkg, rstr_div and the rstr_res_if interface.
`default_nettype none
module rstr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [7:0]                    cfg_wdata,
  input  wire logic [rstr_pkg::HASH_W-1:0]   in_hash,
  input  wire logic signed [7:0]             in_rssi,
  input  wire rstr_pkg::ctl_t                ctl,
  output rstr_pkg::sts_t                     sts,
  rstr_res_if.source                         res
);
  localparam int SLOT_W = rstr_pkg::SLOT_W;
  localparam int TUP_W  = rstr_pkg::TUP_W;
  localparam int LEN_W  = rstr_pkg::LEN_W;

  // slot table; only the used bits reset
  logic                                s_used  [rstr_pkg::SLOTS];
  logic [rstr_pkg::HASH_W-1:0]         s_hash  [rstr_pkg::SLOTS];
  logic [rstr_pkg::COUNT_W-1:0]        s_count [rstr_pkg::SLOTS];
  logic signed [rstr_pkg::SUM_W-1:0]   s_sum   [rstr_pkg::SLOTS];
  logic signed [rstr_pkg::MEAN_W-1:0]  s_mean  [rstr_pkg::SLOTS];

  logic [rstr_pkg::HASH_W-1:0]         m_hash  [rstr_pkg::MAX_TUPLES];
  logic signed [rstr_pkg::MEAN_W-1:0]  m_mean  [rstr_pkg::MAX_TUPLES];
  logic [rstr_pkg::SHORT_W-1:0]        m_count [rstr_pkg::MAX_TUPLES];
  logic [LEN_W-1:0]                    m_len;

  logic [7:0]                          min_packets;
  logic                                wopen;
  logic [rstr_pkg::WP_W-1:0]           wp;
  logic [rstr_pkg::HASH_W-1:0]         h;
  logic signed [7:0]                   rssi;

  logic [SLOT_W-1:0]                   idx;
  logic [TUP_W-1:0]                    mptr;
  logic                                free_v, weak_v, best_v;
  logic [SLOT_W-1:0]                   free_i, weak_i, best_i;
  logic signed [rstr_pkg::MEAN_W-1:0]  weak_mean, top_avg;
  logic [rstr_pkg::HASH_W-1:0]         best_hash;
  logic [rstr_pkg::SHORT_W-1:0]        best_cnt;

  logic                                out_valid;
  logic                                div_done;
  logic signed [rstr_pkg::MEAN_W-1:0]  div_q;

  logic                                cur_used;
  logic [rstr_pkg::COUNT_W-1:0]        cur_count;
  logic signed [rstr_pkg::MEAN_W-1:0]  cur_mean;
  logic [rstr_pkg::SHORT_W-1:0]        cur_short;
  logic                                eligible;
  logic [SLOT_W-1:0]                   take_i;
  logic [TUP_W-1:0]                    inc_p;
  logic                                len_room;
  logic [LEN_W:0]                      mptr_ext;

  rstr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_go),
    .dividend (s_sum[idx]),
    .divisor  (s_count[idx]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    cur_used  = s_used[idx];
    cur_count = s_count[idx];
    cur_mean  = s_mean[idx];
    cur_short = (cur_count > {8'd0, rstr_pkg::SHORT_MAX}) ? rstr_pkg::SHORT_MAX
                                                           : cur_count[rstr_pkg::SHORT_W-1:0];
    eligible  = cur_used && (cur_count >= {8'd0, min_packets});
    take_i    = free_v ? free_i : weak_i;
    len_room  = ({1'b0, m_len} < (LEN_W+1)'(rstr_pkg::MAX_TUPLES));
    inc_p     = len_room ? TUP_W'(m_len) : TUP_W'(rstr_pkg::MAX_TUPLES - 1);
    mptr_ext  = (LEN_W+1)'(mptr);

    sts.in_hash_zero  = (in_hash == '0);
    sts.wopen         = wopen;
    sts.idx_last      = (idx == SLOT_W'(rstr_pkg::SLOTS - 1));
    sts.match_hit     = cur_used && (s_hash[idx] == h);
    sts.count_full    = (cur_count == rstr_pkg::COUNT_MAX);
    sts.note_take     = free_v || (weak_v && (rssi > weak_mean));
    sts.best_v        = best_v;
    sts.tup_full_next = (({1'b0, m_len} + 1'b1) == (LEN_W+1)'(rstr_pkg::MAX_TUPLES));
    sts.msg_hit       = (mptr_ext < {1'b0, m_len}) && (m_hash[mptr] == h);
    sts.msg_more      = ((mptr_ext + 1'b1) < {1'b0, m_len});
    sts.msg_empty     = (m_len == '0);
    sts.emit_last     = ((mptr_ext + 1'b1) == {1'b0, m_len});
    sts.div_done      = div_done;
    sts.out_free      = !out_valid || res.ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_packets <= '0;
      wopen       <= 1'b0;
      wp          <= '0;
      m_len       <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < rstr_pkg::SLOTS; i++) s_used[i] <= 1'b0;
    end else begin
      if (cfg_we) min_packets <= cfg_wdata;
      if (ctl.do_open) begin
        wopen <= 1'b1;
        wp    <= '0;
        m_len <= '0;
        for (int i = 0; i < rstr_pkg::SLOTS; i++) s_used[i] <= 1'b0;
      end
      if (ctl.note_count && (wp != '1)) wp <= wp + 1'b1;
      if (ctl.sum_close) begin
        wopen <= 1'b0;
        m_len <= '0;
      end
      if (ctl.note_write) s_used[take_i] <= 1'b1;
      if (ctl.sum_take) begin
        s_used[best_i] <= 1'b0;
        m_len          <= m_len + 1'b1;
      end
      if (ctl.inc_take) begin
        s_used[idx] <= 1'b0;
        if (len_room) m_len <= m_len + 1'b1;
      end
      if (ctl.out_load)     out_valid <= 1'b1;
      else if (res.ready)   out_valid <= 1'b0;
    end
  end

  // payload: table, message, trackers, output
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      h    <= in_hash;
      rssi <= in_rssi;
    end
    if (ctl.note_write) begin
      s_hash[take_i]  <= h;
      s_count[take_i] <= rstr_pkg::COUNT_W'(1);
      s_sum[take_i]   <= rstr_pkg::SUM_W'(rssi);
      s_mean[take_i]  <= rssi;
    end
    if (ctl.note_bump) begin
      s_count[idx] <= cur_count + 1'b1;
      s_sum[idx]   <= s_sum[idx] + rstr_pkg::SUM_W'(rssi);
    end
    if (ctl.div_store) s_mean[idx] <= div_q;

    if (ctl.scan_clr) begin
      idx    <= '0;
      free_v <= 1'b0;
      weak_v <= 1'b0;
      best_v <= 1'b0;
    end
    if (ctl.step_note) begin
      idx <= idx + 1'b1;
      if (!cur_used) begin
        if (!free_v) begin
          free_v <= 1'b1;
          free_i <= idx;
        end
      end else if (!weak_v || (cur_mean < weak_mean)) begin
        weak_v    <= 1'b1;
        weak_i    <= idx;
        weak_mean <= cur_mean;
      end
    end
    if (ctl.step_rank) begin
      idx <= idx + 1'b1;
      if (eligible && (!best_v || (cur_mean > top_avg))) begin
        best_v    <= 1'b1;
        best_i    <= idx;
        top_avg   <= cur_mean;
        best_hash <= s_hash[idx];
        best_cnt  <= cur_short;
      end
    end
    if (ctl.step_idx) idx <= idx + 1'b1;

    if (ctl.sum_close || ctl.inc_start) mptr <= '0;
    if (ctl.step_msg || ctl.emit_next)  mptr <= mptr + 1'b1;
    if (ctl.sum_take) begin
      m_hash[TUP_W'(m_len)]  <= best_hash;
      m_mean[TUP_W'(m_len)]  <= top_avg;
      m_count[TUP_W'(m_len)] <= best_cnt;
    end
    if (ctl.inc_take) begin
      m_hash[inc_p]  <= s_hash[idx];
      m_mean[inc_p]  <= cur_mean;
      m_count[inc_p] <= cur_short;
      mptr           <= inc_p;
    end

    if (ctl.out_load) begin
      res.total_packets <= wp;
      res.last          <= 1'b1;
      case (ctl.osel)
        rstr_pkg::OSEL_SUM, rstr_pkg::OSEL_INC: begin
          res.kind         <= (ctl.osel == rstr_pkg::OSEL_INC);
          res.valid_res    <= 1'b1;
          res.position     <= 3'(mptr);
          res.source_hash  <= m_hash[mptr];
          res.avg_rssi     <= m_mean[mptr];
          res.packet_count <= m_count[mptr];
          if (ctl.osel == rstr_pkg::OSEL_SUM) res.last <= sts.emit_last;
        end
        default: begin
          res.kind         <= (ctl.osel == rstr_pkg::OSEL_INC_FAIL);
          res.valid_res    <= 1'b0;
          res.position     <= '0;
          res.source_hash  <= '0;
          res.avg_rssi     <= '0;
          res.packet_count <= '0;
        end
      endcase
    end
  end

  assign res.valid = out_valid;
endmodule
`default_nettype wire

// ===== rtl/core/rstr_checker.sv =====
// Port-level assertions for the source table ranker, bound to the top level.
// Depends on rssi_source_table_ranker_core_macros.svh.
`default_nettype none
`include "rssi_source_table_ranker_core_macros.svh"
module rstr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        kind,
  input wire logic        valid_res,
  input wire logic [2:0]  position,
  input wire logic [23:0] source_hash,
  input wire logic [7:0]  packet_count,
  input wire logic        last
);
  `RSTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RSTR_ASSERT_NOW(a_inc_single, out_valid && kind, last)
  `RSTR_ASSERT_NOW(a_fail_zero, out_valid && !valid_res,
                   position == 3'd0 && source_hash == 24'd0 && packet_count == 8'd0)
  `RSTR_ASSERT_NOW(a_empty_last, out_valid && !kind && !valid_res, last)
endmodule

bind rssi_source_table_ranker_core rstr_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .kind         (res.kind),
  .valid_res    (res.valid_res),
  .position     (res.position),
  .source_hash  (res.source_hash),
  .packet_count (res.packet_count),
  .last         (res.last)
);
`default_nettype wire

// ===== sim/rssi_source_table_ranker_core_test.sv =====
// Self-checking testbench for rssi_source_table_ranker_core: random commands in
// well-formed listening windows, scoreboard against an in-bench table predictor.
// Depends on rstr_pkg, rstr_channels and the core RTL.
`timescale 1ns / 1ps
module rssi_source_table_ranker_core_test;
  import rstr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    cmd_t              cmd;
    logic [23:0]       hash;
    logic signed [7:0] rssi;
  } radio_item_t;

  typedef struct packed {
    logic              kind;
    logic              valid_res;
    logic [2:0]        position;
    logic [23:0]       source_hash;
    logic signed [7:0] avg_rssi;
    logic [7:0]        packet_count;
    logic [15:0]       total_packets;
    logic              last;
  } tuple_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  rstr_item_if item_ch ();
  rstr_res_if  res_ch ();

  rssi_source_table_ranker_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .res       (res_ch)
  );

  // Predictor state: a private copy of the source table and the message.
  logic        tbl_used [SLOTS];
  logic [23:0] tbl_hash [SLOTS];
  int          tbl_cnt [SLOTS];
  int          tbl_sum [SLOTS];
  logic        win_open;
  int          win_pkts;
  logic [23:0] msg_hash [MAX_TUPLES];
  int          msg_mean [MAX_TUPLES];
  int          msg_cnt [MAX_TUPLES];
  int          msg_len;
  int          min_pk;

  radio_item_t pending_items [$];
  tuple_t      expected_tuples [$];

  int cycle_count;
  int mismatch_count;
  int items_sent;
  int tuples_seen;
  int summaries_seen;
  int includes_seen;
  int gap_left;
  int burst_left;
  logic took;
  logic stall_mode;
  logic [15:0] stall_pat;

  function automatic int avg_of(int i);
    if (tbl_cnt[i] == 0) return -128;
    return tbl_sum[i] / tbl_cnt[i];
  endfunction

  function automatic int clip_count(int n);
    return (n > 255) ? 255 : n;
  endfunction

  function automatic void clear_message();
    for (int i = 0; i < MAX_TUPLES; i++) begin
      msg_hash[i] = '0;
      msg_mean[i] = 0;
      msg_cnt[i]  = 0;
    end
    msg_len = 0;
  endfunction

  function automatic void push_tuple(logic kind, logic vld, int pos, logic [23:0] h,
                                     int mean, int cnt, logic lst);
    tuple_t t;
    t.kind          = kind;
    t.valid_res     = vld;
    t.position      = pos[2:0];
    t.source_hash   = h;
    t.avg_rssi      = mean[7:0];
    t.packet_count  = cnt[7:0];
    t.total_packets = win_pkts[15:0];
    t.last          = lst;
    expected_tuples.push_back(t);
  endfunction

  function automatic void note_packet(logic [23:0] h, int rssi);
    int free_i;
    int weak_i;
    int t;
    free_i = -1;
    weak_i = -1;
    if (!win_open) return;
    if (win_pkts < 65535) win_pkts++;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_used[i]) begin
        if (free_i < 0) free_i = i;
        continue;
      end
      if (tbl_hash[i] == h) begin
        if (tbl_cnt[i] < 65535) begin
          tbl_cnt[i]++;
          tbl_sum[i] += rssi;
        end
        return;
      end
      if (weak_i < 0 || avg_of(i) < avg_of(weak_i)) weak_i = i;
    end
    t = (free_i >= 0) ? free_i : weak_i;
    if (t < 0) return;
    // full table: evict the weakest only for a strictly louder newcomer
    if (free_i < 0 && rssi <= avg_of(t)) return;
    tbl_used[t] = 1'b1;
    tbl_hash[t] = h;
    tbl_cnt[t]  = 1;
    tbl_sum[t]  = rssi;
  endfunction

  function automatic void rank_window();
    int n;
    int best;
    int top_avg;
    n = 0;
    win_open = 1'b0;
    clear_message();
    while (n < MAX_TUPLES) begin
      best = -1;
      top_avg = -128;
      for (int i = 0; i < SLOTS; i++) begin
        if (!tbl_used[i] || tbl_cnt[i] < min_pk) continue;
        if (best < 0 || avg_of(i) > top_avg) begin
          best = i;
          top_avg = avg_of(i);
        end
      end
      if (best < 0) break;
      msg_hash[n] = tbl_hash[best];
      msg_mean[n] = top_avg;
      msg_cnt[n]  = clip_count(tbl_cnt[best]);
      tbl_used[best] = 1'b0;
      n++;
    end
    msg_len = n;
    if (n == 0) push_tuple(1'b0, 1'b0, 0, '0, 0, 0, 1'b1);
    for (int i = 0; i < n; i++)
      push_tuple(1'b0, 1'b1, i, msg_hash[i], msg_mean[i], msg_cnt[i], i + 1 == n);
  endfunction

  function automatic void include_source(logic [23:0] h);
    int found;
    int p;
    found = -1;
    if (h != 0) begin
      for (int i = 0; i < msg_len; i++) begin
        if (msg_hash[i] == h) begin
          push_tuple(1'b1, 1'b1, i, msg_hash[i], msg_mean[i], msg_cnt[i], 1'b1);
          return;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_used[i] && tbl_hash[i] == h) begin
          found = i;
          break;
        end
      end
    end
    if (found < 0 || tbl_cnt[found] == 0) begin
      push_tuple(1'b1, 1'b0, 0, '0, 0, 0, 1'b1);
      return;
    end
    // full message: the last tuple is overwritten
    if (msg_len < MAX_TUPLES) begin
      p = msg_len;
      msg_len++;
    end else begin
      p = MAX_TUPLES - 1;
    end
    msg_hash[p] = tbl_hash[found];
    msg_mean[p] = avg_of(found);
    msg_cnt[p]  = clip_count(tbl_cnt[found]);
    tbl_used[found] = 1'b0;
    push_tuple(1'b1, 1'b1, p, msg_hash[p], msg_mean[p], msg_cnt[p], 1'b1);
  endfunction

  function automatic void model_item(radio_item_t it);
    case (it.cmd)
      CMD_OPEN: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_used[i] = 1'b0;
          tbl_hash[i] = '0;
          tbl_cnt[i]  = 0;
          tbl_sum[i]  = 0;
        end
        clear_message();
        win_pkts = 0;
        win_open = 1'b1;
      end
      CMD_NOTE:    note_packet(it.hash, int'(it.rssi));
      CMD_SUM:     rank_window();
      CMD_INCLUDE: include_source(it.hash);
      default: ;
    endcase
  endfunction

  function automatic void queue_item(cmd_t c, logic [23:0] h, logic signed [7:0] r);
    radio_item_t it;
    it.cmd  = c;
    it.hash = h;
    it.rssi = r;
    pending_items.push_back(it);
    items_sent++;
  endfunction

  // Hold off until the block is idle, then write min_packets.
  task automatic write_min_packets(logic [7:0] val);
    wait (pending_items.size() == 0 && expected_tuples.size() == 0 && !item_ch.valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    min_pk = val;
  endtask

  // One listening window: open, a burst of notes over a small hash pool so that
  // matches, fills and evictions all happen, then a summary and some includes.
  task automatic run_window(int n_notes, int pool_size, logic flip_stall);
    logic [23:0] pool [32];
    int k;
    for (int i = 0; i < pool_size; i++) pool[i] = 24'($urandom);
    if ($urandom_range(0, 3) == 0) pool[0] = 24'hFFFFFF;
    stall_mode = flip_stall;
    queue_item(CMD_OPEN, 24'($urandom), 8'($urandom));
    for (int i = 0; i < n_notes; i++) begin
      k = $urandom_range(0, 9);
      if (k == 0)
        queue_item(cmd_t'($urandom_range(0, 3)), 24'($urandom), 8'($urandom));
      else if (k == 1)
        queue_item(CMD_INCLUDE, pool[$urandom_range(0, pool_size - 1)], 8'($urandom));
      else
        queue_item(CMD_NOTE, pool[$urandom_range(0, pool_size - 1)], 8'($urandom));
    end
    queue_item(CMD_SUM, 24'($urandom), 8'($urandom));
    for (int i = $urandom_range(0, 5); i > 0; i--) begin
      k = $urandom_range(0, 5);
      queue_item(CMD_INCLUDE, (k == 0) ? 24'd0 : (k == 1) ? 24'($urandom) :
                 pool[$urandom_range(0, pool_size - 1)], 8'($urandom));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Record each accepted item in the predictor and advance the queue.
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) begin
      model_item(pending_items[0]);
      void'(pending_items.pop_front());
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  // Driver: bursts of back-to-back items separated by random gaps.
  always @(negedge clk) begin
    if (!rst && (!item_ch.valid || took)) begin
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 12);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      end else if (burst_left > 0 && gap_left == 0) begin
        burst_left <= burst_left - 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        item_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !(took && pending_items.size() == 0)) begin
        item_ch.valid   <= 1'b1;
        item_ch.command <= pending_items[0].cmd;
        item_ch.hash    <= pending_items[0].hash;
        item_ch.rssi    <= pending_items[0].rssi;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: always ready, or stall on a rotating random pattern.
  always @(negedge clk) begin
    if (!rst) begin
      res_ch.ready <= stall_mode ? stall_pat[0] : 1'b1;
      stall_pat <= ($urandom_range(0, 31) == 0) ? 16'($urandom) : {stall_pat[0], stall_pat[15:1]};
    end
  end

  // Monitor: compare each accepted tuple with the oldest expectation.
  always @(posedge clk) begin
    tuple_t got;
    tuple_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.kind          = res_ch.kind;
      got.valid_res     = res_ch.valid_res;
      got.position      = res_ch.position;
      got.source_hash   = res_ch.source_hash;
      got.avg_rssi      = res_ch.avg_rssi;
      got.packet_count  = res_ch.packet_count;
      got.total_packets = res_ch.total_packets;
      got.last          = res_ch.last;
      if (got.kind) includes_seen++;
      else if (got.last) summaries_seen++;
      tuples_seen++;
      if (expected_tuples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result kind=%0d hash=%h", got.kind, got.source_hash);
      end else begin
        want = expected_tuples.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp kind=%0d v=%0d pos=%0d hash=%h mean=%0d cnt=%0d ",
                      "tot=%0d last=%0d / got kind=%0d v=%0d pos=%0d hash=%h mean=%0d ",
                      "cnt=%0d tot=%0d last=%0d"},
                     want.kind, want.valid_res, want.position, want.source_hash,
                     want.avg_rssi, want.packet_count, want.total_packets, want.last,
                     got.kind, got.valid_res, got.position, got.source_hash,
                     got.avg_rssi, got.packet_count, got.total_packets, got.last);
        end
      end
    end
  end

  initial begin
    logic [7:0] min_choices [6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_OPEN;
    item_ch.hash = '0;
    item_ch.rssi = '0;
    res_ch.ready = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    items_sent = 0;
    tuples_seen = 0;
    summaries_seen = 0;
    includes_seen = 0;
    gap_left = 0;
    burst_left = 0;
    took = 1'b0;
    stall_mode = 1'b0;
    stall_pat = 16'hA5C3;
    min_pk = 0;
    win_open = 1'b0;
    win_pkts = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_hash[i] = '0;
      tbl_cnt[i]  = 0;
      tbl_sum[i]  = 0;
    end
    clear_message();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, extreme fields, message hits, closed window.
    write_min_packets(8'd0);
    queue_item(CMD_INCLUDE, 24'h123456, 8'sd0);
    queue_item(CMD_SUM, 24'd0, 8'sd0);
    queue_item(CMD_OPEN, 24'hFFFFFF, -8'sd128);
    queue_item(CMD_NOTE, 24'hFFFFFF, 8'sd127);
    queue_item(CMD_NOTE, 24'd0, -8'sd128);
    queue_item(CMD_NOTE, 24'h000001, -8'sd1);
    queue_item(CMD_NOTE, 24'h000001, -8'sd2);
    queue_item(CMD_NOTE, 24'h000001, 8'sd1);
    queue_item(CMD_NOTE, 24'hFFFFFF, 8'sd126);
    queue_item(CMD_INCLUDE, 24'd0, 8'sd0);
    queue_item(CMD_INCLUDE, 24'h000001, 8'sd0);
    queue_item(CMD_INCLUDE, 24'h000001, 8'sd0);
    queue_item(CMD_SUM, 24'd0, 8'sd0);
    queue_item(CMD_NOTE, 24'h0000AA, 8'sd5);
    queue_item(CMD_INCLUDE, 24'hFFFFFF, 8'sd0);
    queue_item(CMD_INCLUDE, 24'hABCDEF, 8'sd0);
    queue_item(CMD_SUM, 24'd0, 8'sd0);

    // One heavy source to saturate the reported count, with min_packets at max.
    write_min_packets(8'd255);
    stall_mode = 1'b1;
    queue_item(CMD_OPEN, 24'd0, 8'sd0);
    for (int i = 0; i < 270; i++) queue_item(CMD_NOTE, 24'h5A5A5A, 8'($urandom));
    queue_item(CMD_NOTE, 24'h0F0F0F, -8'sd100);
    queue_item(CMD_SUM, 24'd0, 8'sd0);
    queue_item(CMD_INCLUDE, 24'h0F0F0F, 8'sd0);
    queue_item(CMD_INCLUDE, 24'h5A5A5A, 8'sd0);

    // Random windows under several thresholds; the last one overfills the table.
    min_choices = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd0};
    for (int ph = 0; ph < 6; ph++) begin
      write_min_packets(min_choices[ph]);
      if (ph == 5)
        run_window(28, 24, ph[0]);
      else
        run_window($urandom_range(4, 10), $urandom_range(2, 12), ph[0]);
    end

    wait (pending_items.size() == 0 && expected_tuples.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d summaries, %0d includes, %0d result items",
             items_sent, summaries_seen, includes_seen, tuples_seen);
    $display("min_packets swept over 0, 1, 2, 3 and 255 with sender gaps and result stalls");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
